FILE: src/rkg_pkg.sv
package rkg_pkg;

    // fixed field widths of the item ports
    localparam int unsigned PRIME_PORT_W = 32;
    localparam int unsigned EXP_W        = 16;
    localparam int unsigned KEY_W        = 64;
    localparam int unsigned STATUS_W     = 2;

    // public exponent search range
    localparam logic [EXP_W-1:0] EXP_FIRST = 16'd3;
    localparam logic [EXP_W-1:0] EXP_LAST  = 16'hFFFF;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_P    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_EXP   = 2'd2;

    // operations of the shared shift/add/subtract unit
    typedef enum logic {
        OP_DIV,
        OP_MUL
    } unit_op_t;

    // command from sequencer to the shared unit
    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_WAIT_N,
        ST_MUL_PHI,
        ST_WAIT_PHI,
        ST_GCD_STEP,
        ST_GCD_WAIT,
        ST_INV_STEP,
        ST_INV_WAIT,
        ST_FIN_WAIT,
        ST_DONE
    } state_t;

endpackage

FILE: src/rkg_unit.sv
module rkg_unit
    import rkg_pkg::*;
#(
    parameter int unsigned DW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  unit_cmd_t     cmd,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [DW-1:0] coef,
    output logic          done,
    output logic [DW-1:0] rem,
    output logic [DW-1:0] acc
);

    localparam int unsigned CNT_W = $clog2(DW);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    unit_op_t         op_reg, op_next;
    logic [DW-1:0]    num_reg, num_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW-1:0]    coef_reg, coef_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    acc_reg, acc_next;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;
    logic             qbit;

    // one restoring-division step and one horner step of the product
    always_comb
    begin
        trial = {rem_reg, num_reg[DW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
        qbit  = (op_reg == OP_MUL) ? num_reg[DW-1] : fits;

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        coef_next = coef_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;

        if (cmd.start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            op_next   = cmd.op;
            num_next  = num;
            den_next  = den;
            coef_next = coef;
            rem_next  = '0;
            acc_next  = '0;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[DW-2:0], 1'b0};
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            acc_next = {acc_reg[DW-2:0], 1'b0} + (qbit ? coef_reg : '0);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        coef_reg <= coef_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign acc  = acc_reg;

endmodule

FILE: src/rsa_key_pair_generator.sv
// flow: two products, then a gcd search and an extended euclid; every product or
// division step runs in the shared divide/multiply unit; each candidate exponent is
// tried in turn, then come a final reduction step and the result state
// a prime below two gives its result in the cycle after the item is accepted
// throughput: one item at a time, busy stays high through the result strobe cycle
// reset clears the sequencer and the shared unit control; no clearing pass
module rsa_key_pair_generator
    import rkg_pkg::*;
#(
    parameter int unsigned PRIME_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [PRIME_PORT_W-1:0]   prime_p,
    input  logic [PRIME_PORT_W-1:0]   prime_q,
    output logic                      result_valid,
    output logic [EXP_W-1:0]          public_exponent,
    output logic [KEY_W-1:0]          private_exponent,
    output logic [KEY_W-1:0]          modulus,
    output logic [STATUS_W-1:0]       status
);

    localparam int unsigned PW = PRIME_WIDTH;
    localparam int unsigned DW = 2 * PRIME_WIDTH;

    state_t             state_reg, state_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [PW-1:0]      q_reg, q_next;
    logic [DW-1:0]      n_reg, n_next;
    logic [DW-1:0]      phi_reg, phi_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic [DW-1:0]      r0_reg, r0_next;
    logic [DW-1:0]      r1_reg, r1_next;
    logic [DW-1:0]      c0_reg, c0_next;
    logic [DW-1:0]      c1_reg, c1_next;
    logic               neg0_reg, neg0_next;
    logic               neg1_reg, neg1_next;
    logic [DW-1:0]      d_reg, d_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [PW-1:0]      p_in;
    logic [PW-1:0]      q_in;
    unit_cmd_t          cmd;
    logic [DW-1:0]      u_num;
    logic [DW-1:0]      u_den;
    logic [DW-1:0]      u_coef;
    logic               u_done;
    logic [DW-1:0]      u_rem;
    logic [DW-1:0]      u_acc;

    assign p_in = prime_p[PW-1:0];
    assign q_in = prime_q[PW-1:0];

    // shared divide / multiply unit
    rkg_unit #(
        .DW (DW)
    ) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .num   (u_num),
        .den   (u_den),
        .coef  (u_coef),
        .done  (u_done),
        .rem   (u_rem),
        .acc   (u_acc)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        n_next      = n_reg;
        phi_next    = phi_reg;
        e_next      = e_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        neg0_next   = neg0_reg;
        neg1_next   = neg1_reg;
        d_next      = d_reg;
        status_next = status_reg;

        cmd.start = 1'b0;
        cmd.op    = OP_DIV;
        u_num     = r0_reg;
        u_den     = r1_reg;
        u_coef    = c1_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    p_next = p_in;
                    q_next = q_in;
                    if ((p_in < PW'(2)) || (q_in < PW'(2)))
                    begin
                        n_next      = '0;
                        e_next      = '0;
                        d_next      = '0;
                        status_next = STATUS_BAD_P;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        state_next  = ST_MUL_N;
                    end
                end
            end
            ST_MUL_N:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                u_num      = DW'(p_reg);
                u_coef     = DW'(q_reg);
                state_next = ST_WAIT_N;
            end
            ST_WAIT_N:
            begin
                if (u_done)
                begin
                    n_next     = u_acc;
                    state_next = ST_MUL_PHI;
                end
            end
            ST_MUL_PHI:
            begin
                cmd.start  = 1'b1;
                cmd.op     = OP_MUL;
                u_num      = DW'(p_reg - 1'b1);
                u_coef     = DW'(q_reg - 1'b1);
                state_next = ST_WAIT_PHI;
            end
            ST_WAIT_PHI:
            begin
                if (u_done)
                begin
                    phi_next   = u_acc;
                    e_next     = EXP_FIRST;
                    r0_next    = DW'(EXP_FIRST);
                    r1_next    = u_acc;
                    state_next = ST_GCD_STEP;
                end
            end
            // euclid gcd of candidate exponent and phi
            ST_GCD_STEP:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg == DW'(1))
                    begin
                        r0_next    = phi_reg;
                        r1_next    = DW'(e_reg);
                        c0_next    = '0;
                        c1_next    = DW'(1);
                        neg0_next  = 1'b0;
                        neg1_next  = 1'b0;
                        state_next = ST_INV_STEP;
                    end
                    else if (e_reg == EXP_LAST)
                    begin
                        e_next      = '0;
                        d_next      = '0;
                        status_next = STATUS_NO_EXP;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        e_next  = e_reg + 1'b1;
                        r0_next = DW'(e_reg + 1'b1);
                        r1_next = phi_reg;
                    end
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:
            begin
                if (u_done)
                begin
                    r0_next    = r1_reg;
                    r1_next    = u_rem;
                    state_next = ST_GCD_STEP;
                end
            end
            // extended euclid, coefficient kept as magnitude with sign
            ST_INV_STEP:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg != DW'(1))
                    begin
                        d_next     = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        u_num      = c0_reg;
                        u_den      = phi_reg;
                        state_next = ST_FIN_WAIT;
                    end
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_INV_WAIT;
                end
            end
            ST_INV_WAIT:
            begin
                if (u_done)
                begin
                    r0_next    = r1_reg;
                    r1_next    = u_rem;
                    c0_next    = c1_reg;
                    c1_next    = c0_reg + u_acc;
                    neg0_next  = neg1_reg;
                    neg1_next  = !neg1_reg;
                    state_next = ST_INV_STEP;
                end
            end
            // reduce the coefficient into range and apply its sign
            ST_FIN_WAIT:
            begin
                if (u_done)
                begin
                    if (neg0_reg && (u_rem != '0))
                        d_next = phi_reg - u_rem;
                    else
                        d_next = u_rem;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        q_reg      <= q_next;
        n_reg      <= n_next;
        phi_reg    <= phi_next;
        e_reg      <= e_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        c0_reg     <= c0_next;
        c1_reg     <= c1_next;
        neg0_reg   <= neg0_next;
        neg1_reg   <= neg1_next;
        d_reg      <= d_next;
        status_reg <= status_next;
    end

    // result ports
    assign busy             = (state_reg != ST_IDLE);
    assign result_valid     = (state_reg == ST_DONE);
    assign public_exponent  = e_reg;
    assign private_exponent = KEY_W'(d_reg);
    assign modulus          = KEY_W'(n_reg);
    assign status           = status_reg;

endmodule

FILE: verif/tb_rsa_key_pair_generator.sv
module tb_rsa_key_pair_generator;

    import rkg_pkg::*;

    localparam int unsigned PRIME_W     = 32;
    localparam int unsigned STALL_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYC  = 200;

    // one key pair as it appears on the result ports
    typedef struct packed {
        logic [EXP_W-1:0]    public_exponent;
        logic [KEY_W-1:0]    private_exponent;
        logic [KEY_W-1:0]    modulus;
        logic [STATUS_W-1:0] status;
    } key_pair_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [PRIME_PORT_W-1:0] prime_p;
    logic [PRIME_PORT_W-1:0] prime_q;
    logic                    result_valid;
    logic [EXP_W-1:0]        public_exponent;
    logic [KEY_W-1:0]        private_exponent;
    logic [KEY_W-1:0]        modulus;
    logic [STATUS_W-1:0]     status;

    key_pair_t   expected_keys[$];
    int unsigned mismatch_count;
    int unsigned stall_cycles;
    int unsigned sender_idle_pct;
    int unsigned small_primes[10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};

    rsa_key_pair_generator #(
        .PRIME_WIDTH(PRIME_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .prime_p(prime_p),
        .prime_q(prime_q),
        .result_valid(result_valid),
        .public_exponent(public_exponent),
        .private_exponent(private_exponent),
        .modulus(modulus),
        .status(status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // plain euclid gcd on 64-bit values
    function automatic logic [KEY_W-1:0] common_divisor(logic [KEY_W-1:0] a,
                                                         logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] rem;
        while (b != 0)
        begin
            rem = a % b;
            a   = b;
            b   = rem;
        end
        return a;
    endfunction

    // extended euclid, coefficients kept as magnitude with alternating sign
    function automatic logic [KEY_W-1:0] modular_inverse(logic [KEY_W-1:0] e,
                                                          logic [KEY_W-1:0] m);
        logic [KEY_W-1:0] r_prev, r_cur, r_next, quot;
        logic [KEY_W-1:0] k_prev, k_cur, k_next;
        bit               neg_prev, neg_cur, neg_next;
        r_prev   = m;
        r_cur    = e;
        k_prev   = '0;
        k_cur    = 1;
        neg_prev = 1'b0;
        neg_cur  = 1'b0;
        while (r_cur != 0)
        begin
            quot     = r_prev / r_cur;
            r_next   = r_prev - quot * r_cur;
            k_next   = k_prev + quot * k_cur;
            neg_next = !neg_cur;
            r_prev   = r_cur;
            r_cur    = r_next;
            k_prev   = k_cur;
            neg_prev = neg_cur;
            k_cur    = k_next;
            neg_cur  = neg_next;
        end
        if (r_prev != 1)
            return '0;
        k_prev = k_prev % m;
        if (neg_prev && k_prev != 0)
            return m - k_prev;
        return k_prev;
    endfunction

    // expected key pair for one pair of primes
    function automatic key_pair_t predict_key_pair(logic [PRIME_PORT_W-1:0] p_in,
                                                    logic [PRIME_PORT_W-1:0] q_in);
        key_pair_t        kp;
        logic [KEY_W-1:0] mask, p, q, phi;
        bit               found;
        int               exp_pick;
        kp       = '0;
        mask     = (64'd1 << PRIME_W) - 1;
        p        = {32'd0, p_in} & mask;
        q        = {32'd0, q_in} & mask;
        found    = 1'b0;
        exp_pick = 0;
        if (p < 2 || q < 2)
        begin
            kp.status = STATUS_BAD_P;
            return kp;
        end
        kp.modulus = p * q;
        phi        = (p - 1) * (q - 1);
        for (int cand = int'(EXP_FIRST); cand <= int'(EXP_LAST); cand++)
        begin
            if (common_divisor(KEY_W'(cand), phi) == 1)
            begin
                exp_pick = cand;
                found    = 1'b1;
                break;
            end
        end
        if (!found)
        begin
            kp.status = STATUS_NO_EXP;
            return kp;
        end
        kp.status           = STATUS_OK;
        kp.public_exponent  = EXP_W'(exp_pick);
        kp.private_exponent = modular_inverse(KEY_W'(exp_pick), phi);
        return kp;
    endfunction

    // value one above a product of small primes, gives phi many small factors
    function automatic logic [PRIME_PORT_W-1:0] smooth_plus_one();
        logic [KEY_W-1:0] v;
        v = 64'd2;
        for (int k = 0; k < 12; k++)
        begin
            v = v * small_primes[$urandom_range(0, 9)];
            if (v > 64'h0FFF_FFFF)
                break;
        end
        return v[PRIME_PORT_W-1:0] + 1;
    endfunction

    // send one item, with a random idle gap before it
    task automatic send_primes(input logic [PRIME_PORT_W-1:0] p,
                               input logic [PRIME_PORT_W-1:0] q);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        prime_p <= p;
        prime_q <= q;
        do
            @(posedge clk);
        while (busy);
        expected_keys.push_back(predict_key_pair(p, q));
    endtask

    // hold off until every expected key pair has come back
    task automatic wait_all_keys();
        if (start)
            start <= 1'b0;
        do
            @(posedge clk);
        while (expected_keys.size() != 0);
    endtask

    // p or q below two
    task automatic test_prime_below_two();
        send_primes(32'd0, 32'd0);
        send_primes(32'd0, 32'd7);
        send_primes(32'd1, 32'd13);
        send_primes(32'd13, 32'd1);
        send_primes(32'd1, 32'd1);
        send_primes(32'd0, 32'hFFFF_FFFF);
        send_primes(32'hFFFF_FFFF, 32'd1);
        wait_all_keys();
    endtask

    // smallest and largest inputs, phi of one, non-prime inputs
    task automatic test_corner_values();
        send_primes(32'd2, 32'd2);
        send_primes(32'd2, 32'd3);
        send_primes(32'd3, 32'd2);
        send_primes(32'd3, 32'd3);
        send_primes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_primes(32'd4294967291, 32'd4294967279);
        send_primes(32'd2, 32'd4294967291);
        send_primes(32'd65537, 32'd65521);
        send_primes(32'd100, 32'd221);
        wait_all_keys();
    endtask

    // phi with many small factors pushes the exponent search out
    task automatic test_exponent_search();
        send_primes(32'd7, 32'd13);
        send_primes(32'd31, 32'd31);
        send_primes(32'd211, 32'd2311);
        send_primes(32'd223092871, 32'd2727567);
        wait_all_keys();
    endtask

    // random pairs: mostly full width, some tiny, some with smooth phi
    task automatic test_random_keys(input int count, input int unsigned idle_pct);
        logic [PRIME_PORT_W-1:0] p, q;
        int unsigned             kind;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    p = $urandom_range(0, 20);
                    q = $urandom_range(0, 20);
                end
                1:
                begin
                    p = smooth_plus_one();
                    q = smooth_plus_one();
                end
                2:
                begin
                    p = smooth_plus_one();
                    q = $urandom;
                end
                default:
                begin
                    p = $urandom;
                    q = $urandom;
                end
            endcase
            send_primes(p, q);
            if ($urandom_range(0, 15) == 0)
                wait_all_keys();
        end
        wait_all_keys();
    endtask

    // result checker
    always @(posedge clk)
    begin
        key_pair_t seen, want;
        if (rst_n && result_valid)
        begin
            seen = '{public_exponent, private_exponent, modulus, status};
            if (expected_keys.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected key pair: e=%0d d=%h n=%h status=%0d",
                             seen.public_exponent, seen.private_exponent,
                             seen.modulus, seen.status);
                mismatch_count++;
            end
            else
            begin
                want = expected_keys.pop_front();
                if (seen.public_exponent !== want.public_exponent ||
                    seen.private_exponent !== want.private_exponent ||
                    seen.modulus !== want.modulus ||
                    seen.status !== want.status)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("key mismatch at %0t", $realtime);
                        $display("  exp: e=%0d d=%h n=%h status=%0d",
                                 want.public_exponent, want.private_exponent,
                                 want.modulus, want.status);
                        $display("  got: e=%0d d=%h n=%h status=%0d",
                                 seen.public_exponent, seen.private_exponent,
                                 seen.modulus, seen.status);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        prime_p         = '0;
        prime_q         = '0;
        mismatch_count  = 0;
        stall_cycles    = 0;
        sender_idle_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_prime_below_two();
        test_corner_values();
        test_exponent_search();

        // sender idling phases; the result side has no stall
        test_random_keys(30, 0);
        test_random_keys(30, 82);
        test_random_keys(30, 0);
        test_random_keys(30, 37);

        // let any stray result show up
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatch_count == 0 && expected_keys.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: rsa_key_pair_generator.f
src/rkg_pkg.sv
src/rkg_unit.sv
src/rsa_key_pair_generator.sv
verif/tb_rsa_key_pair_generator.sv
